[rtl/pptk_pkg.sv]
// Package: types, constants and codes shared by the primer pair ranker.
`timescale 1ns / 1ps
package pptk_pkg;

    localparam int MAX_PAIRS    = 16;
    localparam int ID_BITS      = 16;
    localparam int RANK_BITS    = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
    localparam int COUNT_BITS   = $clog2(MAX_PAIRS + 1);
    localparam int RATING_BITS  = 22;
    localparam int WEIGHT_BITS  = 12;
    localparam int ACTIVE_BITS  = 5;
    localparam int GC_BITS      = 7;
    localparam int TEMP_BITS    = 8;
    localparam int GC_PROD_BITS   = GC_BITS + WEIGHT_BITS;
    localparam int TEMP_PROD_BITS = TEMP_BITS + WEIGHT_BITS;
    localparam int CFG_IDX_BITS = 2;
    localparam int CFG_DATA_BITS = 12;
    localparam int ACTIVE_LIMIT = (MAX_PAIRS < 16) ? MAX_PAIRS : 16;

    localparam logic [WEIGHT_BITS-1:0] GC_WEIGHT_RESET   = 12'd128;
    localparam logic [WEIGHT_BITS-1:0] TEMP_WEIGHT_RESET = 12'd128;
    localparam logic [ACTIVE_BITS-1:0] ACTIVE_RESET      = 5'd10;

    localparam logic [CFG_IDX_BITS-1:0] REG_GC_WEIGHT    = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_TEMP_WEIGHT  = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_ACTIVE_COUNT = 2'd2;

    localparam logic KIND_OFFER = 1'b0;
    localparam logic KIND_READ  = 1'b1;

    typedef logic [RATING_BITS-1:0] rating_t;
    typedef logic [ID_BITS-1:0]     id_t;

    typedef struct packed {
        logic        kind;
        logic [15:0] left_id;
        logic [6:0]  left_gc;
        logic [7:0]  left_temp;
        logic [15:0] right_id;
        logic [6:0]  right_gc;
        logic [7:0]  right_temp;
        logic [3:0]  read_rank;
    } in_item_t;

    typedef struct packed {
        logic        inserted;
        logic [3:0]  insert_rank;
        logic        entry_valid;
        logic [21:0] entry_rating;
        logic [15:0] entry_left;
        logic [15:0] entry_right;
    } out_item_t;

    typedef struct packed {
        logic    valid;
        rating_t rating;
        id_t     left;
        id_t     right;
    } entry_t;

    typedef struct packed {
        logic    update;
        logic    clear;
        rating_t rating;
    } cell_ctrl_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_SUM,
        ST_UPD
    } state_t;

endpackage

[rtl/pptk_if.sv]
// Channel interfaces: offered/read items in, result items out.
`timescale 1ns / 1ps
interface pptk_in_if;
    logic               valid;
    logic               ready;
    pptk_pkg::in_item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface pptk_out_if;
    logic                valid;
    logic                ready;
    pptk_pkg::out_item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

[rtl/primer_pair_top_k_ranker.sv]
// Top level of the primer pair ranker: control, rating unit and the chain of list cells.
//
//   channel   dir  handshake          payload
//   item      in   valid/ready        kind, ids, gc, temp, read_rank
//   result    out  valid/ready        inserted, insert_rank, entry_*
//   wr_*      in   wr_en (no ready)   wr_index, wr_data
//
// The result passes the item register, the product register, the sum
// register, then the list update and result register. The next item can
// transfer only once the block is back in its idle state.
// A new item is taken while the previous result is being transferred.
// Reset empties the list; writing active_count empties it as well.
// A stalled result holds the block until it is transferred.
`timescale 1ns / 1ps
module primer_pair_top_k_ranker
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    pptk_in_if.sink                              item,
    pptk_out_if.source                           result,
    input  logic                                 wr_en,
    input  logic [pptk_pkg::CFG_IDX_BITS-1:0]    wr_index,
    input  logic [pptk_pkg::CFG_DATA_BITS-1:0]   wr_data
);

    localparam int N = pptk_pkg::MAX_PAIRS;

    pptk_pkg::state_t                    state_reg;
    pptk_pkg::state_t                    state_next;
    logic [pptk_pkg::WEIGHT_BITS-1:0]    gc_weight_reg;
    logic [pptk_pkg::WEIGHT_BITS-1:0]    temp_weight_reg;
    logic [pptk_pkg::ACTIVE_BITS-1:0]    active_reg;
    pptk_pkg::in_item_t                  item_reg;
    logic                                out_valid_reg;
    logic                                out_valid_next;
    pptk_pkg::out_item_t                 out_item_reg;
    pptk_pkg::out_item_t                 out_item_next;

    logic                                accept;
    logic                                clear_list;
    logic [pptk_pkg::COUNT_BITS-1:0]     used;
    logic [pptk_pkg::RANK_BITS-1:0]      last_idx;
    logic [pptk_pkg::RANK_BITS-1:0]      read_idx;
    logic                                read_in_range;
    logic                                do_insert;
    logic [pptk_pkg::RANK_BITS-1:0]      pos;
    pptk_pkg::rating_t                   rating;
    pptk_pkg::cell_ctrl_t                cell_ctrl;
    pptk_pkg::entry_t                    new_entry;
    pptk_pkg::entry_t                    cells   [N];
    logic [N-1:0]                        keep_vec;
    logic [N-1:0]                        valid_vec;

    assign accept     = item.valid && item.ready;
    assign clear_list = wr_en && (wr_index == pptk_pkg::REG_ACTIVE_COUNT);

    // 0 acts as 1, large values saturate to the list depth
    always_comb
    begin
        if (active_reg == '0)
        begin
            used = pptk_pkg::COUNT_BITS'(1);
        end
        else if (32'(active_reg) > pptk_pkg::ACTIVE_LIMIT)
        begin
            used = pptk_pkg::COUNT_BITS'(pptk_pkg::ACTIVE_LIMIT);
        end
        else
        begin
            used = pptk_pkg::COUNT_BITS'(active_reg);
        end
    end

    assign last_idx = pptk_pkg::RANK_BITS'(used - pptk_pkg::COUNT_BITS'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gc_weight_reg   <= pptk_pkg::GC_WEIGHT_RESET;
            temp_weight_reg <= pptk_pkg::TEMP_WEIGHT_RESET;
            active_reg      <= pptk_pkg::ACTIVE_RESET;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                pptk_pkg::REG_GC_WEIGHT:    gc_weight_reg   <= wr_data;
                pptk_pkg::REG_TEMP_WEIGHT:  temp_weight_reg <= wr_data;
                pptk_pkg::REG_ACTIVE_COUNT: active_reg      <= wr_data[pptk_pkg::ACTIVE_BITS-1:0];
                default:                    ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item.payload;
        end
    end

    pptk_rater u_rater
    (
        .clk         (clk),
        .mul_en      (state_reg == pptk_pkg::ST_MUL),
        .sum_en      (state_reg == pptk_pkg::ST_SUM),
        .left_gc     (item_reg.left_gc),
        .right_gc    (item_reg.right_gc),
        .left_temp   (item_reg.left_temp),
        .right_temp  (item_reg.right_temp),
        .gc_weight   (gc_weight_reg),
        .temp_weight (temp_weight_reg),
        .rating      (rating)
    );

    assign do_insert = (state_reg == pptk_pkg::ST_UPD) && (item_reg.kind == pptk_pkg::KIND_OFFER)
                       && !keep_vec[last_idx];

    assign cell_ctrl.update = do_insert;
    assign cell_ctrl.clear  = clear_list;
    assign cell_ctrl.rating = rating;

    assign new_entry.valid  = 1'b1;
    assign new_entry.rating = rating;
    assign new_entry.left   = pptk_pkg::ID_BITS'(item_reg.left_id);
    assign new_entry.right  = pptk_pkg::ID_BITS'(item_reg.right_id);

    genvar g;
    generate
        for (g = 0; g < N; g++)
        begin : g_cell
            if (g == 0)
            begin : g_head
                pptk_cell u_cell
                (
                    .clk        (clk),
                    .rst_n      (rst_n),
                    .ctrl       (cell_ctrl),
                    .keep_prev  (1'b1),
                    .prev_entry (new_entry),
                    .new_entry  (new_entry),
                    .keep       (keep_vec[g]),
                    .entry      (cells[g])
                );
            end
            else
            begin : g_body
                pptk_cell u_cell
                (
                    .clk        (clk),
                    .rst_n      (rst_n),
                    .ctrl       (cell_ctrl),
                    .keep_prev  (keep_vec[g-1]),
                    .prev_entry (cells[g-1]),
                    .new_entry  (new_entry),
                    .keep       (keep_vec[g]),
                    .entry      (cells[g])
                );
            end
            assign valid_vec[g] = cells[g].valid;
        end
    endgenerate

    // keep bits form a prefix of the sorted list, so the count is the slot
    assign pos = pptk_pkg::RANK_BITS'($countones(keep_vec));

    assign read_idx      = pptk_pkg::RANK_BITS'(item_reg.read_rank);
    assign read_in_range = ({1'b0, item_reg.read_rank} < 5'(used))
                           && (32'(item_reg.read_rank) < N);

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        out_item_next  = out_item_reg;
        item.ready     = 1'b0;
        if (out_valid_reg && result.ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            pptk_pkg::ST_IDLE:
            begin
                item.ready = !out_valid_reg || result.ready;
                if (accept)
                begin
                    state_next = pptk_pkg::ST_MUL;
                end
            end
            pptk_pkg::ST_MUL:
            begin
                state_next = pptk_pkg::ST_SUM;
            end
            pptk_pkg::ST_SUM:
            begin
                state_next = pptk_pkg::ST_UPD;
            end
            pptk_pkg::ST_UPD:
            begin
                state_next     = pptk_pkg::ST_IDLE;
                out_valid_next = 1'b1;
                out_item_next  = '0;
                if (item_reg.kind == pptk_pkg::KIND_READ)
                begin
                    if (read_in_range && cells[read_idx].valid)
                    begin
                        out_item_next.entry_valid  = 1'b1;
                        out_item_next.entry_rating = cells[read_idx].rating;
                        out_item_next.entry_left   = 16'(cells[read_idx].left);
                        out_item_next.entry_right  = 16'(cells[read_idx].right);
                    end
                end
                else
                begin
                    out_item_next.entry_rating = rating;
                    if (do_insert)
                    begin
                        out_item_next.inserted    = 1'b1;
                        out_item_next.insert_rank = 4'(pos);
                    end
                end
            end
            default:
            begin
                state_next = pptk_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pptk_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_item_reg <= out_item_next;
    end

    assign result.valid   = out_valid_reg;
    assign result.payload = out_item_reg;

    // occupied cells always form a prefix of the list
    a_valid_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        ((valid_vec & (valid_vec + N'(1))) == '0))
        else $error("list cells not a contiguous prefix");

    // latency from transfer to result is fixed
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##4 result.valid)
        else $error("result missing four cycles after transfer");

    // an inserted pair always lands inside the active list
    a_rank_range: assert property (@(posedge clk) disable iff (!rst_n)
        do_insert |-> (pos <= last_idx))
        else $error("insert position beyond active list");

    // an offer result never reports a stored entry
    a_offer_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.payload.inserted) |-> !result.payload.entry_valid)
        else $error("offer result carries entry data");

endmodule

[rtl/pptk_rater.sv]
// Two-stage rating unit: weighted products, then their sum.
`timescale 1ns / 1ps
module pptk_rater
(
    input  logic                                clk,
    input  logic                                mul_en,
    input  logic                                sum_en,
    input  logic [pptk_pkg::GC_BITS-1:0]        left_gc,
    input  logic [pptk_pkg::GC_BITS-1:0]        right_gc,
    input  logic [pptk_pkg::TEMP_BITS-1:0]      left_temp,
    input  logic [pptk_pkg::TEMP_BITS-1:0]      right_temp,
    input  logic [pptk_pkg::WEIGHT_BITS-1:0]    gc_weight,
    input  logic [pptk_pkg::WEIGHT_BITS-1:0]    temp_weight,
    output pptk_pkg::rating_t                   rating
);

    logic [pptk_pkg::GC_BITS-1:0]        dgc;
    logic [pptk_pkg::TEMP_BITS-1:0]      dt;
    logic [pptk_pkg::GC_PROD_BITS-1:0]   gc_prod_reg;
    logic [pptk_pkg::TEMP_PROD_BITS-1:0] temp_prod_reg;
    pptk_pkg::rating_t                   rating_reg;

    assign dgc = (left_gc > right_gc) ? (left_gc - right_gc) : (right_gc - left_gc);
    assign dt  = (left_temp > right_temp) ? (left_temp - right_temp)
                                          : (right_temp - left_temp);

    always_ff @(posedge clk)
    begin
        if (mul_en)
        begin
            gc_prod_reg   <= pptk_pkg::GC_PROD_BITS'(dgc) * pptk_pkg::GC_PROD_BITS'(gc_weight);
            temp_prod_reg <= pptk_pkg::TEMP_PROD_BITS'(dt)
                             * pptk_pkg::TEMP_PROD_BITS'(temp_weight);
        end
        if (sum_en)
        begin
            rating_reg <= pptk_pkg::RATING_BITS'(gc_prod_reg)
                          + pptk_pkg::RATING_BITS'(temp_prod_reg);
        end
    end

    assign rating = rating_reg;

endmodule

[rtl/pptk_cell.sv]
// One list cell: holds an entry, keeps it, takes the new pair or its upper neighbor's.
`timescale 1ns / 1ps
module pptk_cell
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  pptk_pkg::cell_ctrl_t ctrl,
    input  logic                 keep_prev,
    input  pptk_pkg::entry_t     prev_entry,
    input  pptk_pkg::entry_t     new_entry,
    output logic                 keep,
    output pptk_pkg::entry_t     entry
);

    logic              valid_reg;
    logic              valid_next;
    pptk_pkg::rating_t rating_reg;
    pptk_pkg::rating_t rating_next;
    pptk_pkg::id_t     left_reg;
    pptk_pkg::id_t     left_next;
    pptk_pkg::id_t     right_reg;
    pptk_pkg::id_t     right_next;

    // entry stays ahead of the new pair when it rates at least as high
    assign keep = valid_reg && (rating_reg >= ctrl.rating);

    always_comb
    begin
        valid_next  = valid_reg;
        rating_next = rating_reg;
        left_next   = left_reg;
        right_next  = right_reg;
        if (ctrl.clear)
        begin
            valid_next = 1'b0;
        end
        else if (ctrl.update && !keep)
        begin
            if (keep_prev)
            begin
                valid_next  = new_entry.valid;
                rating_next = new_entry.rating;
                left_next   = new_entry.left;
                right_next  = new_entry.right;
            end
            else
            begin
                valid_next  = prev_entry.valid;
                rating_next = prev_entry.rating;
                left_next   = prev_entry.left;
                right_next  = prev_entry.right;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rating_reg <= rating_next;
        left_reg   <= left_next;
        right_reg  <= right_next;
    end

    assign entry.valid  = valid_reg;
    assign entry.rating = rating_reg;
    assign entry.left   = left_reg;
    assign entry.right  = right_reg;

endmodule
